FILE: design/gmps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the grid max path sum block.
// No dependencies; every other file of the block imports this package.
package gmps_pkg;

  // Field widths fixed by the interface.
  localparam int CELL_W     = 16;
  localparam int ENERGY_W   = 32;
  localparam int CFG_W      = 5;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Largest side the side register can express.
  localparam int SIDE_CODE_MAX = (1 << CFG_W) - 1;

  // Register map, indexed by paddr[APB_ADDR_W-1:2].
  localparam logic [APB_ADDR_W-3:0] REG_SIDE = 1'b0;
  localparam logic [CFG_W-1:0]      SIDE_RST = 5'd16;

  // Result codes.
  localparam logic KIND_MOVE   = 1'b0;
  localparam logic KIND_ENERGY = 1'b1;
  localparam logic MOVE_EAST   = 1'b0;
  localparam logic MOVE_SOUTH  = 1'b1;

  // Depth of the queue between the load front and the solver back.
  localparam int QUEUE_DEPTH = 2;

  // One loaded cell, tagged with its place in the grid.
  typedef struct packed {
    logic signed [CELL_W-1:0] value;
    logic                     row_end;
    logic                     grid_end;
  } cell_entry_t;

endpackage

FILE: design/gmps_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for cell requests and result requests.
// Depends on gmps_pkg for the field widths.
interface gmps_in_if;
  import gmps_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmps_out_if;
  import gmps_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic                       move_south;
  logic signed [ENERGY_W-1:0] energy;
  logic                       last;

  modport source (output valid, output kind, output move_south, output energy,
                  output last, input ready);
  modport sink   (input valid, input kind, input move_south, input energy,
                  input last, output ready);
endinterface

FILE: design/grid_max_path_sum.sv
`timescale 1ns / 1ps
// Grid max path sum: a load front, a short queue, and a solver back.
// Usage:
//   in_chan carries one signed 16-bit cell request per accepted beat, row by
//   row and left to right. The front takes one cell per cycle while the queue
//   has room. The APB port holds the side register (side N) at byte address 0.
//   out_chan carries 2N-2 move requests (kind 0, move_south) and then one
//   energy request (kind 1, best sum times 40, last = 1).
// Sequencing:
//   After the last cell, the sweep visits each cell in a read state and a
//   calculate state (one grid store access pair and one add/compare per cell),
//   then the trace reads and emits each move, and then the energy request.
//   The next grid's cells queue up and are stored once the current run is
//   out.
// Reset:
//   The side register returns to 16 and the load position to the first cell;
//   the grid store itself is not cleared, since every entry in use is written first.
// Stalls:
//   A stalled receiver holds the output register; the back then waits, the
//   two-entry queue fills, and in_chan.ready drops.
module grid_max_path_sum #(
  parameter int MAX_SIDE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  gmps_in_if.sink                             in_chan,
  gmps_out_if.source                          out_chan,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gmps_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [gmps_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [gmps_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import gmps_pkg::*;

  localparam int IDX_W    = MAX_SIDE > 1 ? $clog2(MAX_SIDE) : 1;
  localparam int SIDE_CAP = MAX_SIDE < SIDE_CODE_MAX ? MAX_SIDE : SIDE_CODE_MAX;

  logic [CFG_W-1:0]        side_cfg_r;
  logic [CFG_W-1:0]        side;
  logic [IDX_W-1:0]        last_idx;
  logic                    cfg_wr;
  logic [APB_ADDR_W-3:0]   reg_idx;

  logic        push;
  cell_entry_t push_data;
  logic        full;
  logic        pop;
  cell_entry_t pop_data;
  logic        q_valid;

  // Register access.
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_SIDE);
  assign prdata  = (reg_idx == REG_SIDE) ? APB_DATA_W'(side_cfg_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_cfg_r <= SIDE_RST;
    end else if (cfg_wr) begin
      side_cfg_r <= pwdata[CFG_W-1:0];
    end
  end

  // Side in use, clamped to 1..SIDE_CAP (MAX_SIDE, at most SIDE_CODE_MAX), as a last row/column index.
  always_comb begin
    priority if (side_cfg_r == '0) begin
      side = CFG_W'(1);
    end else if (side_cfg_r > CFG_W'(SIDE_CAP)) begin
      side = CFG_W'(SIDE_CAP);
    end else begin
      side = side_cfg_r;
    end
    last_idx = IDX_W'(side - 1'b1);
  end

  gmps_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_wr),
    .last_idx  (last_idx),
    .in_chan   (in_chan),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  gmps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_wr),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .valid     (q_valid)
  );

  gmps_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (cfg_wr),
    .last_idx (last_idx),
    .q_valid  (q_valid),
    .q_data   (pop_data),
    .q_pop    (pop),
    .out_chan (out_chan)
  );

endmodule

FILE: design/gmps_front.sv
`timescale 1ns / 1ps
// Load front: accepts cell requests and tags each with row end and grid end.
// Depends on gmps_pkg and gmps_in_if.
module gmps_front #(
  parameter int MAX_SIDE = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  logic [(MAX_SIDE > 1 ? $clog2(MAX_SIDE) : 1)-1:0] last_idx,
  gmps_in_if.sink                  in_chan,
  output logic                     push,
  output gmps_pkg::cell_entry_t    push_data,
  input  logic                     full
);
  import gmps_pkg::*;

  localparam int IDX_W = MAX_SIDE > 1 ? $clog2(MAX_SIDE) : 1;

  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic             row_end;
  logic             grid_end;

  // Take a cell whenever the queue has room.
  assign in_chan.ready = !full;
  assign push          = in_chan.valid && !full;

  assign row_end  = (col_r == last_idx);
  assign grid_end = row_end && (row_r == last_idx);

  assign push_data.value    = in_chan.cell_value;
  assign push_data.row_end  = row_end;
  assign push_data.grid_end = grid_end;

  // Position of the next cell in row-major order.
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (push) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = grid_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  a_grid_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (push && grid_end) |=> (row_r == '0 && col_r == '0))
    else $error("grid end did not wrap the load position");

endmodule

FILE: design/gmps_queue.sv
`timescale 1ns / 1ps
// Short queue of tagged cells between the load front and the solver back.
// Depends on gmps_pkg for the entry type and depth.
module gmps_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear,
  input  logic                  push,
  input  gmps_pkg::cell_entry_t push_data,
  output logic                  full,
  input  logic                  pop,
  output gmps_pkg::cell_entry_t pop_data,
  output logic                  valid
);
  import gmps_pkg::*;

  localparam int PTR_W = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cell_entry_t      entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = entry_r[rd_ptr_r];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("queue popped while empty");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop && !clear) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

FILE: design/gmps_back.sv
`timescale 1ns / 1ps
// Solver back: stores cells, sweeps best sums from the bottom-right corner,
// traces the path and drives result requests. Depends on gmps_pkg, gmps_out_if.
module gmps_back #(
  parameter int MAX_SIDE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear,
  input  logic [(MAX_SIDE > 1 ? $clog2(MAX_SIDE) : 1)-1:0] last_idx,
  input  logic                  q_valid,
  input  gmps_pkg::cell_entry_t q_data,
  output logic                  q_pop,
  gmps_out_if.source            out_chan
);
  import gmps_pkg::*;

  localparam int IDX_W  = MAX_SIDE > 1 ? $clog2(MAX_SIDE) : 1;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int SUM_W  = CELL_W + $clog2(2 * MAX_SIDE);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SW_RD,
    S_SW_CALC,
    S_TR_RD,
    S_TR_EMIT,
    S_ENERGY
  } state_t;

  state_t state_r;

  logic signed [SUM_W-1:0] mem [DEPTH];
  logic signed [SUM_W-1:0] rd_a_r;
  logic signed [SUM_W-1:0] rd_b_r;
  logic [ADDR_W-1:0]       addr_a;
  logic [ADDR_W-1:0]       addr_b;
  logic [ADDR_W-1:0]       waddr;
  logic signed [SUM_W-1:0] wdata;
  logic                    we;

  logic [IDX_W-1:0] wr_row_r;
  logic [IDX_W-1:0] wr_col_r;
  logic [IDX_W-1:0] r_r;
  logic [IDX_W-1:0] c_r;
  logic [IDX_W-1:0] r_inc;
  logic [IDX_W-1:0] c_inc;
  logic             at_r_last;
  logic             at_c_last;

  logic signed [SUM_W-1:0]    east_r;
  logic signed [SUM_W-1:0]    best_r;
  logic signed [SUM_W-1:0]    addend;
  logic signed [SUM_W-1:0]    sum;
  logic                       south;
  logic                       reached;
  logic signed [ENERGY_W-1:0] best_ext;
  logic signed [ENERGY_W-1:0] energy;

  logic                       out_valid_r;
  logic                       out_kind_r;
  logic                       out_south_r;
  logic signed [ENERGY_W-1:0] out_energy_r;
  logic                       out_last_r;
  logic                       out_free;
  logic                       out_load;

  assign r_inc     = r_r + 1'b1;
  assign c_inc     = c_r + 1'b1;
  assign at_r_last = (r_r == last_idx);
  assign at_c_last = (c_r == last_idx);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign out_load  = out_free && (state_r == S_TR_EMIT || state_r == S_ENERGY);
  assign q_pop     = (state_r == S_LOAD) && q_valid;

  // Read addresses: the sweep reads the cell and its south neighbor,
  // the trace keeps reading the east and south neighbors until it moves.
  assign addr_a = (state_r == S_TR_RD || state_r == S_TR_EMIT) ? {r_r, c_inc} : {r_r, c_r};
  assign addr_b = {r_inc, c_r};

  // Write port: loaded cells, then best sums in place.
  always_comb begin
    we    = 1'b0;
    waddr = {r_r, c_r};
    wdata = sum;
    if (q_pop) begin
      we    = 1'b1;
      waddr = {wr_row_r, wr_col_r};
      wdata = SUM_W'(q_data.value);
    end else if (state_r == S_SW_CALC) begin
      we = 1'b1;
    end
  end

  // Best sum of the current cell from its east and south successors.
  always_comb begin
    priority if (at_r_last && at_c_last) begin
      addend = '0;
    end else if (at_r_last) begin
      addend = east_r;
    end else if (at_c_last) begin
      addend = rd_b_r;
    end else begin
      addend = (east_r >= rd_b_r) ? east_r : rd_b_r;
    end
    sum = rd_a_r + addend;
  end

  // Trace decision, east preferred on ties.
  always_comb begin
    priority if (at_c_last) begin
      south = MOVE_SOUTH;
    end else if (at_r_last) begin
      south = MOVE_EAST;
    end else begin
      south = (rd_a_r >= rd_b_r) ? MOVE_EAST : MOVE_SOUTH;
    end
    reached = south ? (r_inc == last_idx && at_c_last)
                    : (at_r_last && c_inc == last_idx);
  end

  // Energy is the best sum times 40, formed as 32x + 8x.
  assign best_ext = ENERGY_W'(best_r);
  assign energy   = (best_ext <<< 5) + (best_ext <<< 3);

  // Grid store with two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      wr_row_r    <= '0;
      wr_col_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      if (clear) begin
        wr_row_r <= '0;
        wr_col_r <= '0;
      end else if (q_pop) begin
        if (q_data.row_end) begin
          wr_col_r <= '0;
          wr_row_r <= q_data.grid_end ? '0 : wr_row_r + 1'b1;
        end else begin
          wr_col_r <= wr_col_r + 1'b1;
        end
      end
      unique case (state_r)
        S_LOAD: begin
          if (q_pop && q_data.grid_end) begin
            r_r     <= last_idx;
            c_r     <= last_idx;
            state_r <= S_SW_RD;
          end
        end
        S_SW_RD: begin
          state_r <= S_SW_CALC;
        end
        S_SW_CALC: begin
          east_r <= sum;
          if (c_r == '0 && r_r == '0) begin
            best_r  <= sum;
            state_r <= (last_idx == '0) ? S_ENERGY : S_TR_RD;
          end else if (c_r == '0) begin
            r_r     <= r_r - 1'b1;
            c_r     <= last_idx;
            state_r <= S_SW_RD;
          end else begin
            c_r     <= c_r - 1'b1;
            state_r <= S_SW_RD;
          end
        end
        S_TR_RD: begin
          state_r <= S_TR_EMIT;
        end
        S_TR_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_MOVE;
            out_south_r  <= south;
            out_energy_r <= '0;
            out_last_r   <= 1'b0;
            if (south) begin
              r_r <= r_inc;
            end else begin
              c_r <= c_inc;
            end
            state_r <= reached ? S_ENERGY : S_TR_RD;
          end
        end
        S_ENERGY: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_ENERGY;
            out_south_r  <= MOVE_EAST;
            out_energy_r <= energy;
            out_last_r   <= 1'b1;
            state_r      <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.kind       = out_kind_r;
  assign out_chan.move_south = out_south_r;
  assign out_chan.energy     = out_energy_r;
  assign out_chan.last       = out_last_r;

  a_trace_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TR_EMIT) |-> (r_r <= last_idx && c_r <= last_idx))
    else $error("trace left the grid");

  a_energy_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENERGY && out_free) |=>
      (state_r == S_LOAD && out_valid_r && out_last_r && out_kind_r == KIND_ENERGY))
    else $error("energy request did not close the run");

  a_sweep_steps_west: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SW_CALC && c_r != '0) |=>
      (state_r == S_SW_RD && c_r + 1'b1 == $past(c_r)))
    else $error("sweep did not step one cell west");

endmodule
